[rtl/slm_pkg.sv]
// slm_pkg: shared types, constants and command codes for the sorted list merge.
// Used by slm_ctrl, slm_dp, sorted_list_merge and slm_checker; depends on nothing.
`default_nettype none

package slm_pkg;

  // List storage sizing
  localparam int LIST_DEPTH = 32;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // Field widths
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 6;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Request command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } slm_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
  } slm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic last_one;
    logic out_free;
  } slm_stat_t;

endpackage

`default_nettype wire

[rtl/slm_ctrl.sv]
// slm_ctrl: controller state machine for the sorted list merge.
// Depends on slm_pkg; drives slm_dp through slm_cmd_t and reads slm_stat_t.
`default_nettype none

module slm_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  input  wire logic [slm_pkg::CMD_W-1:0] in_command,
  output logic                          in_tready,
  input  wire slm_pkg::slm_stat_t       stat,
  output slm_pkg::slm_cmd_t             cmd
);
  import slm_pkg::*;

  slm_state_t state_r;
  slm_state_t state_nxt;
  logic       in_fire;

  assign in_fire = in_tvalid && in_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_command == CMD_MERGE && !stat.empty) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (stat.out_free && stat.last_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: take requests only while idle, step the merge when the output slot frees
  always_comb begin
    in_tready  = 1'b0;
    cmd.load_a = 1'b0;
    cmd.load_b = 1'b0;
    cmd.step   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.load_a = in_tvalid && in_command == CMD_LOAD_A;
        cmd.load_b = in_tvalid && in_command == CMD_LOAD_B;
      end
      ST_MERGE: begin
        cmd.step = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/slm_dp.sv]
// slm_dp: datapath for the sorted list merge: two list memories, fill counts,
// tail compare and the output register. Depends on slm_pkg.
`default_nettype none

module slm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire slm_pkg::slm_cmd_t            cmd,
  output slm_pkg::slm_stat_t                stat,
  input  wire logic signed [slm_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [slm_pkg::VALUE_W-1:0] out_value,
  output logic [slm_pkg::POS_W-1:0]         out_position,
  output logic                              out_last
);
  import slm_pkg::*;

  logic signed [VALUE_W-1:0] mem_a [LIST_DEPTH];
  logic signed [VALUE_W-1:0] mem_b [LIST_DEPTH];

  logic [CNT_W-1:0]          cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]          cnt_b_r, cnt_b_nxt;
  logic signed [VALUE_W-1:0] rd_a_r, rd_b_r;
  logic [IDX_W-1:0]          rd_addr_a, rd_addr_b;
  logic [SUM_W-1:0]          remain;
  logic                      pick_a;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [POS_W-1:0]          out_pos_r;
  logic                      out_last_r;

  // Compare the two tails; the first list wins ties
  assign remain = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};
  assign pick_a = (cnt_a_r != '0) && ((cnt_b_r == '0) || (rd_a_r >= rd_b_r));

  // Advance fill counts: grow on loads that fit, shrink as the merge consumes
  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (cmd.load_a && cnt_a_r < CNT_W'(LIST_DEPTH)) begin
      cnt_a_nxt = cnt_a_r + CNT_W'(1);
    end
    if (cmd.load_b && cnt_b_r < CNT_W'(LIST_DEPTH)) begin
      cnt_b_nxt = cnt_b_r + CNT_W'(1);
    end
    if (cmd.step) begin
      if (pick_a) begin
        cnt_a_nxt = cnt_a_r - CNT_W'(1);
      end else begin
        cnt_b_nxt = cnt_b_r - CNT_W'(1);
      end
    end
  end

  // Read the tail each list will have after this cycle
  assign rd_addr_a = IDX_W'(cnt_a_nxt - CNT_W'(1));
  assign rd_addr_b = IDX_W'(cnt_b_nxt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
    end
  end

  // List memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.load_a && cnt_a_r < CNT_W'(LIST_DEPTH)) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= in_value;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_b && cnt_b_r < CNT_W'(LIST_DEPTH)) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= in_value;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_value_r <= pick_a ? rd_a_r : rd_b_r;
      out_pos_r   <= POS_W'(remain - SUM_W'(1));
      out_last_r  <= (remain == SUM_W'(1));
    end
  end

  assign stat.empty    = (remain == '0);
  assign stat.last_one = (remain == SUM_W'(1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

[rtl/sorted_list_merge.sv]
// sorted_list_merge: top level; loads two ascending lists and emits their merge
// largest first. After acceptance of a merge request, the controller enters its merge
// state and each result is registered in the output register. Throughput: one load
// request per cycle while idle; a merge emits one result per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties both lists and the output register.
`default_nettype none

module sorted_list_merge (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [slm_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  wire logic [slm_pkg::CMD_W-1:0]      in_tuser,   // [1:0] command
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [slm_pkg::OUT_DATA_W-1:0]      out_tdata,  // [31:0] merged_value, [37:32] position
  output logic                                out_tlast
);
  import slm_pkg::*;

  slm_cmd_t                  cmd;
  slm_stat_t                 stat;
  logic signed [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]          out_position;

  slm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser),
    .in_tready  (in_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  slm_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_value     (in_tdata[VALUE_W-1:0]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_value    (out_value),
    .out_position (out_position),
    .out_last     (out_tlast)
  );

  // Pack result fields, zero pad to whole bytes
  assign out_tdata = {{(OUT_DATA_W - VALUE_W - POS_W){1'b0}}, out_position, out_value};

endmodule

`default_nettype wire

[rtl/slm_checker.sv]
// slm_checker: port-level assertions for sorted_list_merge, bound to the top level.
// Depends on slm_pkg.
`default_nettype none

module slm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [slm_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tlast
);
  import slm_pkg::*;

  // The final result of a run sits at position zero
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[VALUE_W +: POS_W] == '0)
    else $error("last result not at position zero");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // A run streams without gaps until its last result
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside merge run");

  // No requests taken while a run is in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request accepted during merge");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
